// ----- design/random_pixel_jitter_top_macros.svh -----
// ----------------------------------------------------------------------------
// Random pixel jitter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and muted in reset.
// ----------------------------------------------------------------------------
`ifndef RANDOM_PIXEL_JITTER_TOP_MACROS_SVH
`define RANDOM_PIXEL_JITTER_TOP_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define RPJ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in a cycle implies a consequence in the same cycle.
`define RPJ_IMPLY(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

// Condition in a cycle implies a consequence in the next cycle.
`define RPJ_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rpj_pkg.sv -----
// ----------------------------------------------------------------------------
// Random pixel jitter package
// Types, constants and helper functions shared by the jitter block.
// ----------------------------------------------------------------------------
package rpj_pkg;

  // Generator constants; the second step is folded into one multiply-add.
  localparam logic [31:0] LCG_MUL  = 32'd1103516245;
  localparam logic [31:0] LCG_ADD  = 32'd12345;
  localparam logic [31:0] LCG_MUL2 = 32'(64'(LCG_MUL) * 64'(LCG_MUL));
  localparam logic [31:0] LCG_ADD2 = 32'(64'(LCG_ADD) * 64'(LCG_MUL) + 64'(LCG_ADD));

  localparam int unsigned JITTER_BIAS = 2;
  localparam int unsigned MODE_COUNT  = 15;
  localparam int unsigned MAX_DIM     = 512;
  // Smallest table shift is 21, so a shifted draw fits in 11 bits.
  localparam int unsigned JIT_W       = 11;
  // Width of flat addresses and frame limits (covers the largest store).
  localparam int unsigned CALC_W      = 23;
  localparam int unsigned Q_DEPTH     = 4;
  localparam int unsigned PTR_W       = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W       = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } rpj_cfg_idx_e;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_EMIT = 1'b1
  } rpj_req_type_e;

  typedef struct packed {
    logic [3:0] mode;
    logic [9:0] width;
    logic [9:0] height;
  } rpj_cfg_t;

  // One classified request for the frame store.
  typedef struct packed {
    logic              emit;
    logic [CALC_W-1:0] addr;
    logic [7:0]        pix;
  } rpj_req_t;

  // A dimension of zero acts as one, anything above the maximum as the maximum.
  function automatic logic [9:0] rpj_clamp_dim(input logic [9:0] v);
    if (v == 10'd0) begin
      return 10'd1;
    end
    if (v > 10'(MAX_DIM)) begin
      return 10'(MAX_DIM);
    end
    return v;
  endfunction

  // Shift amount per mode; modes past the table use the last entry.
  function automatic logic [4:0] rpj_shift(input logic [3:0] mode);
    logic [3:0] m;
    m = (mode >= 4'(MODE_COUNT)) ? 4'(MODE_COUNT - 1) : mode;
    unique case (m)
      4'd0:    return 5'd30;
      4'd1:    return 5'd28;
      4'd2:    return 5'd26;
      4'd3:    return 5'd27;
      4'd4:    return 5'd25;
      4'd5:    return 5'd24;
      4'd6:    return 5'd23;
      4'd7:    return 5'd22;
      4'd8:    return 5'd21;
      4'd9:    return 5'd25;
      4'd10:   return 5'd26;
      4'd11:   return 5'd24;
      4'd12:   return 5'd23;
      4'd13:   return 5'd22;
      default: return 5'd21;
    endcase
  endfunction

endpackage

// ----- design/rpj_front.sv -----
// ----------------------------------------------------------------------------
// Random pixel jitter front end
// Accepts requests, draws the displacement, clamps coordinates and forms the
// flat store address of each load or emit.
// ----------------------------------------------------------------------------
module rpj_front #(
  parameter int unsigned FRAME_PIXELS = 262144
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      req_type_i,
  input  logic [8:0]                pos_x_i,
  input  logic [8:0]                pos_y_i,
  input  logic [7:0]                pixel_in_i,
  input  rpj_pkg::rpj_cfg_t         cfg_i,
  input  logic [rpj_pkg::CNT_W-1:0] q_count_i,
  output logic                      push_o,
  output rpj_pkg::rpj_req_t         push_req_o
);
  import rpj_pkg::*;

  localparam int unsigned SUM_W = CNT_W + 1;

  // Displace one coordinate and clamp it into the active frame.
  function automatic logic [8:0] jit_coord(input logic [8:0] pos,
                                           input logic [JIT_W-1:0] d,
                                           input logic [9:0] lim);
    logic [11:0] s;
    logic [11:0] m;
    logic [9:0]  lm1;
    s   = 12'(pos) + 12'(d);
    m   = s - 12'(JITTER_BIAS);
    lm1 = lim - 10'd1;
    if (s < 12'(JITTER_BIAS) || m >= 12'(lim)) begin
      return lm1[8:0];
    end
    return m[8:0];
  endfunction

  logic [9:0]        w_eff, h_eff;
  logic [4:0]        shamt;
  logic              accept;
  logic              is_emit;
  logic [31:0]       draw1_q, draw1_d, draw2_q, draw2_d;
  logic [CALC_W-1:0] lim_q, lim_d;
  logic [19:0]       area;
  logic [SUM_W-1:0]  inflight;

  logic              s1_vld_q;
  logic              s1_emit_q;
  logic [8:0]        s1_x_q, s1_y_q;
  logic [7:0]        s1_pix_q;
  logic [JIT_W-1:0]  s1_dx_q, s1_dy_q;

  logic [8:0]        xd, yd;
  logic              in_frame;

  logic              s2_vld_q;
  logic              s2_emit_q;
  logic              s2_ok_q;
  logic [8:0]        s2_xd_q;
  logic [7:0]        s2_pix_q;
  logic [18:0]       s2_prod_q;

  logic [CALC_W-1:0] addr;

  assign w_eff = rpj_clamp_dim(cfg_i.width);
  assign h_eff = rpj_clamp_dim(cfg_i.height);
  assign shamt = rpj_shift(cfg_i.mode);

  // Hold off new requests while the queue could not absorb all in flight.
  assign inflight = SUM_W'(q_count_i) + SUM_W'(s1_vld_q) + SUM_W'(s2_vld_q);
  assign busy     = (inflight >= SUM_W'(Q_DEPTH));
  assign accept   = start && !busy;
  assign is_emit  = (req_type_i == REQ_EMIT);

  // Generator keeps the next two draws; one emit consumes both.
  assign draw1_d = draw2_q * LCG_MUL + LCG_ADD;
  assign draw2_d = draw2_q * LCG_MUL2 + LCG_ADD2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw1_q <= LCG_ADD;
      draw2_q <= LCG_ADD2;
    end else if (accept && is_emit) begin
      draw1_q <= draw1_d;
      draw2_q <= draw2_d;
    end
  end

  // Frame limit is registered from the dimension registers.
  assign area  = 20'(w_eff) * 20'(h_eff);
  assign lim_d = (CALC_W'(area) > CALC_W'(FRAME_PIXELS)) ? CALC_W'(FRAME_PIXELS)
                                                         : CALC_W'(area);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= CALC_W'(FRAME_PIXELS);
    end else begin
      lim_q <= lim_d;
    end
  end

  // Stage one: capture the request and its shifted draws.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_emit_q <= is_emit;
      s1_x_q    <= pos_x_i;
      s1_y_q    <= pos_y_i;
      s1_pix_q  <= pixel_in_i;
      s1_dy_q   <= JIT_W'(draw1_q >> shamt);
      s1_dx_q   <= JIT_W'(draw2_q >> shamt);
    end
  end

  // Emits are displaced and clamped; loads keep their position.
  always_comb begin
    if (s1_emit_q) begin
      xd = jit_coord(s1_x_q, s1_dx_q, w_eff);
      yd = jit_coord(s1_y_q, s1_dy_q, h_eff);
    end else begin
      xd = s1_x_q;
      yd = s1_y_q;
    end
    in_frame = (10'(s1_x_q) < w_eff) && (10'(s1_y_q) < h_eff);
  end

  // Stage two: line offset product.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_emit_q <= s1_emit_q;
      s2_ok_q   <= in_frame;
      s2_xd_q   <= xd;
      s2_pix_q  <= s1_pix_q;
      s2_prod_q <= 19'(yd) * 19'(w_eff);
    end
  end

  // Flat address; emits clamp to the last pixel, stray loads are dropped.
  always_comb begin
    addr = CALC_W'(s2_xd_q) + CALC_W'(s2_prod_q);
    if (s2_emit_q && (addr >= lim_q)) begin
      addr = lim_q - CALC_W'(1);
    end
    push_req_o.emit = s2_emit_q;
    push_req_o.addr = addr;
    push_req_o.pix  = s2_pix_q;
    push_o = s2_vld_q &&
             (s2_emit_q || (s2_ok_q && (addr < CALC_W'(FRAME_PIXELS))));
  end

endmodule

// ----- design/rpj_fifo.sv -----
// ----------------------------------------------------------------------------
// Random pixel jitter request queue
// Short first-in first-out queue between the front end and the store.
// ----------------------------------------------------------------------------
`include "random_pixel_jitter_top_macros.svh"

module rpj_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  rpj_pkg::rpj_req_t         push_req_i,
  input  logic                      pop_i,
  output logic                      valid_o,
  output rpj_pkg::rpj_req_t         req_o,
  output logic [rpj_pkg::CNT_W-1:0] count_o
);
  import rpj_pkg::*;

  rpj_req_t         slots_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_pop;

  assign valid_o = (count_q != CNT_W'(0));
  assign req_o   = slots_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_pop  = pop_i && valid_o;

  // Occupancy follows pushes and pops.
  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_req_i;
    end
  end

  `RPJ_IMPLY(a_no_overflow, push_i, (count_q < CNT_W'(Q_DEPTH)) || pop_i, "queue overflow")
  `RPJ_NEXT(a_count_grows, push_i && !do_pop, count_q == $past(count_q) + CNT_W'(1), "count lost a push")

endmodule

// ----- design/rpj_back.sv -----
// ----------------------------------------------------------------------------
// Random pixel jitter back end
// Frame store: performs queued loads and reads the pixel for each emit.
// ----------------------------------------------------------------------------
`include "random_pixel_jitter_top_macros.svh"

module rpj_back #(
  parameter int unsigned FRAME_PIXELS = 262144
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  rpj_pkg::rpj_req_t req_i,
  output logic              pop_o,
  output logic              done_o,
  output logic [7:0]        pixel_out_o
);
  import rpj_pkg::*;

  localparam int unsigned ADDR_W = $clog2(FRAME_PIXELS);

  logic [7:0]        mem [FRAME_PIXELS];
  logic [ADDR_W-1:0] mem_addr;
  logic              done_q;
  logic [7:0]        rd_data_q;

  // The store takes one request every cycle, so the queue drains at once.
  assign pop_o    = req_valid_i;
  assign mem_addr = req_i.addr[ADDR_W-1:0];

  // Single-port store: a load writes, an emit reads.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (req_i.emit) begin
        rd_data_q <= mem[mem_addr];
      end else begin
        mem[mem_addr] <= req_i.pix;
      end
    end
  end

  // Result strobe, one cycle per emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= pop_o && req_i.emit;
    end
  end

  assign done_o      = done_q;
  assign pixel_out_o = rd_data_q;

  `RPJ_NEXT(a_emit_gives_done, pop_o && req_i.emit, done_o, "emit produced no result")
  `RPJ_ASSERT(a_done_from_emit, !done_o || $past(pop_o && req_i.emit), "result without emit")

endmodule

// ----- design/random_pixel_jitter_top.sv -----
// ----------------------------------------------------------------------------
// Random pixel jitter top level
// Frame store with a randomly displaced read-back of luma pixels.
// ----------------------------------------------------------------------------
// Usage: a request is taken at a clock edge where start is high and busy is
// low. With req_type_i low it loads pixel_in_i at (pos_x_i, pos_y_i); loads
// outside the active frame are dropped and never give a result. With
// req_type_i high it emits: done_o pulses for exactly one cycle with the pixel
// read from a jittered position, after the front-end stages, the queue and the store.
// Results leave in request order and the receiver cannot hold them off.
// Throughput is one request per clock while busy is low; the limit is the generator
// loop, a single 32-bit multiply-add that advances two draws per emit. busy
// rises only if the request queue between front end and store could fill.
// Configuration (mode, frame width, frame height) is written through the
// cfg channel, which is always ready; write it only while no request is in
// flight. Reset sets mode 1, a 512 by 512 frame and the generator seed; the
// frame store contents stay undefined until loaded and are not cleared.
// ----------------------------------------------------------------------------
module random_pixel_jitter_top #(
  parameter int unsigned FRAME_PIXELS = 262144
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       req_type_i,
  input  logic [8:0] pos_x_i,
  input  logic [8:0] pos_y_i,
  input  logic [7:0] pixel_in_i,
  output logic       done_o,
  output logic [7:0] pixel_out_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [9:0] cfg_data_i
);
  import rpj_pkg::*;

  rpj_cfg_t         cfg_q;
  logic             push;
  rpj_req_t         push_req;
  logic             q_valid;
  rpj_req_t         q_req;
  logic [CNT_W-1:0] q_count;
  logic             pop;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= 4'd1;
      cfg_q.width  <= 10'(MAX_DIM);
      cfg_q.height <= 10'(MAX_DIM);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MODE:   cfg_q.mode   <= cfg_data_i[3:0];
        CFG_WIDTH:  cfg_q.width  <= cfg_data_i;
        CFG_HEIGHT: cfg_q.height <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front end: accept, draw and address.
  rpj_front #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_type_i (req_type_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pixel_in_i (pixel_in_i),
    .cfg_i      (cfg_q),
    .q_count_i  (q_count),
    .push_o     (push),
    .push_req_o (push_req)
  );

  // Queue between front end and store.
  rpj_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .req_o      (q_req),
    .count_o    (q_count)
  );

  // Back end: frame store and result.
  rpj_back #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (q_valid),
    .req_i       (q_req),
    .pop_o       (pop),
    .done_o      (done_o),
    .pixel_out_o (pixel_out_o)
  );

endmodule

// ----- dv/random_pixel_jitter_checker.sv -----
// ----------------------------------------------------------------------------
// Random pixel jitter checker
// Watches the request, result and register channels of the jitter block. It
// keeps its own frame store, generator and register copy, and works out the
// pixel that each emit request must return. Each strobed result is compared
// with the oldest pixel still owed.
// ----------------------------------------------------------------------------
module random_pixel_jitter_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        req_type_i,
  input  logic [8:0]  pos_x_i,
  input  logic [8:0]  pos_y_i,
  input  logic [7:0]  pixel_in_i,
  input  logic        done_i,
  input  logic [7:0]  pixel_out_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  localparam int unsigned STORE_DEPTH = 262144;
  localparam int unsigned MODES       = 15;
  localparam int unsigned PRINT_CAP   = 50;
  localparam logic [31:0] DRAW_MUL    = 32'd1103516245;
  localparam logic [31:0] DRAW_INC    = 32'd12345;
  localparam logic [31:0] DRAW_BIAS   = 32'd2;
  localparam logic [31:0] DIM_MAX     = 32'd512;
  // Shift per mode, five bits each, mode 0 in the lowest slice.
  localparam logic [MODES*5-1:0] SHIFT_TABLE = {
    5'd21, 5'd22, 5'd23, 5'd24, 5'd26, 5'd25, 5'd21, 5'd22,
    5'd23, 5'd24, 5'd25, 5'd27, 5'd26, 5'd28, 5'd30
  };

  // Predictor state.
  logic [7:0]  luma_frame [STORE_DEPTH];
  logic [31:0] lcg_state;
  logic [3:0]  cfg_mode;
  logic [9:0]  cfg_width;
  logic [9:0]  cfg_height;
  logic [7:0]  pixel_expect_q [$];
  int unsigned mismatch_count = 0;

  // Working values of one request.
  logic [31:0] span_w, span_h, span_lim;
  logic [31:0] draw_y, draw_x, dst_x, dst_y, flat;
  logic [3:0]  mode_used;
  logic [4:0]  shift_amt;
  logic [7:0]  want_pixel;

  assign pending_o    = pixel_expect_q.size();
  assign fail_count_o = mismatch_count;

  // A zero dimension acts as one, anything past the maximum as the maximum.
  function automatic logic [31:0] dim_in_use(input logic [9:0] v);
    logic [31:0] d;
    d = {22'd0, v};
    if (d == 32'd0) begin
      d = 32'd1;
    end else if (d > DIM_MAX) begin
      d = DIM_MAX;
    end
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_state  = '0;
      cfg_mode   = 4'd1;
      cfg_width  = 10'd512;
      cfg_height = 10'd512;
      pixel_expect_q.delete();
    end else begin
      // Register writes.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          rpj_pkg::CFG_MODE:   cfg_mode   = cfg_data_i[3:0];
          rpj_pkg::CFG_WIDTH:  cfg_width  = cfg_data_i;
          rpj_pkg::CFG_HEIGHT: cfg_height = cfg_data_i;
          default: ;
        endcase
      end

      // Results leave in request order; compare with the oldest one owed.
      if (done_i) begin
        if (pixel_expect_q.size() == 0) begin
          report_mismatch($sformatf("pixel_out 0x%02h with no emit request waiting",
                                    pixel_out_i));
        end else begin
          want_pixel = pixel_expect_q.pop_front();
          if (pixel_out_i !== want_pixel) begin
            report_mismatch($sformatf("pixel_out 0x%02h, expected 0x%02h",
                                      pixel_out_i, want_pixel));
          end
        end
      end

      // Accepted request.
      if (start_i && !busy_i) begin
        span_w   = dim_in_use(cfg_width);
        span_h   = dim_in_use(cfg_height);
        span_lim = span_w * span_h;
        if (span_lim > STORE_DEPTH) begin
          span_lim = STORE_DEPTH;
        end
        if (req_type_i == rpj_pkg::REQ_LOAD) begin
          // Loads outside the active frame are dropped.
          if ({23'd0, pos_x_i} < span_w && {23'd0, pos_y_i} < span_h) begin
            flat = {23'd0, pos_x_i} + {23'd0, pos_y_i} * span_w;
            if (flat < STORE_DEPTH) begin
              luma_frame[flat] = pixel_in_i;
            end
          end
        end else begin
          mode_used = (cfg_mode >= MODES) ? 4'(MODES - 1) : cfg_mode;
          shift_amt = SHIFT_TABLE[mode_used*5 +: 5];
          // Two draws per emit: the first moves y, the second moves x.
          draw_y    = lcg_state * DRAW_MUL + DRAW_INC;
          draw_x    = draw_y * DRAW_MUL + DRAW_INC;
          lcg_state = draw_x;
          dst_y = {23'd0, pos_y_i} + (draw_y >> shift_amt) - DRAW_BIAS;
          dst_x = {23'd0, pos_x_i} + (draw_x >> shift_amt) - DRAW_BIAS;
          // A negative offset wraps high and clamps like any overshoot.
          if (dst_x >= span_w) begin
            dst_x = span_w - 1;
          end
          if (dst_y >= span_h) begin
            dst_y = span_h - 1;
          end
          flat = dst_x + dst_y * span_w;
          if (flat >= span_lim) begin
            flat = span_lim - 1;
          end
          pixel_expect_q.push_back(luma_frame[flat]);
        end
      end
    end
  end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Random pixel jitter testbench
// Loads the first row of the store once, then runs directed requests at the
// field extremes and the clamping corners, followed by random phases of loads
// and emits under changing mode and frame sizes, with random idle bursts.
// Every frame size after the first row keeps its pixel count within that row,
// so no emit can read a store entry that was never loaded. A separate checker
// predicts every emitted pixel and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;

  import rpj_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 20_000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned CALM_ITEMS   = 150;
  // Store entries loaded up front; every frame used afterwards fits in them.
  localparam int unsigned FILL_PIXELS  = 512;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       start      = 1'b0;
  logic       busy;
  logic       req_type   = 1'b0;
  logic [8:0] pos_x      = '0;
  logic [8:0] pos_y      = '0;
  logic [7:0] pixel_in   = '0;
  logic       done;
  logic [7:0] pixel_out;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index  = '0;
  logic [9:0] cfg_data   = '0;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned act_w = 512;
  int unsigned act_h = 512;
  int unsigned items_done;
  int unsigned phase_len;
  int unsigned k;
  int unsigned fx;
  bit          idle_on;
  logic [8:0]  rx, ry;
  logic [9:0]  wv, hv;

  random_pixel_jitter_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .pixel_in_i  (pixel_in),
    .done_o      (done),
    .pixel_out_o (pixel_out),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  random_pixel_jitter_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_type_i   (req_type),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .pixel_in_i   (pixel_in),
    .done_i       (done),
    .pixel_out_i  (pixel_out),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Frame size as the block uses it, for choosing positions inside the frame.
  function automatic int unsigned dim_in_use(input logic [9:0] v);
    if (v == 10'd0) begin
      return 1;
    end
    return (v > 10'd512) ? 512 : int'(v);
  endfunction

  // Frame width register value, mostly legal, sometimes at or past the ends.
  function automatic logic [9:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 10'd1;
      1:       return 10'd512;
      2:       return 10'd0;
      3:       return 10'($urandom_range(513, 1023));
      4, 5:    return 10'($urandom_range(1, 16));
      default: return 10'($urandom_range(1, 512));
    endcase
  endfunction

  // Frame height register value that keeps the frame within the loaded row.
  function automatic logic [9:0] pick_height(input int unsigned w_use);
    int unsigned cap;
    cap = FILL_PIXELS / w_use;
    case ($urandom_range(0, 5))
      0:       return 10'd0;
      1:       return 10'd1;
      2:       return 10'(cap);
      3:       return (cap == 512) ? 10'($urandom_range(513, 1023)) : 10'(cap);
      default: return 10'($urandom_range(1, cap));
    endcase
  endfunction

  // Hold one request on the ports until the block takes it.
  task automatic send_request(input rpj_req_type_e kind, input logic [8:0] x,
                              input logic [8:0] y, input logic [7:0] pix);
    req_type <= kind;
    pos_x    <= x;
    pos_y    <= y;
    pixel_in <= pix;
    start    <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_gap(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Wait until every owed pixel is back and the pipeline has emptied.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all three registers back to back; valid stays high throughout.
  task automatic configure(input logic [3:0] mode, input logic [9:0] w,
                           input logic [9:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= {6'd0, mode};
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= CFG_WIDTH;
    cfg_data  <= w;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    act_w = dim_in_use(w);
    act_h = dim_in_use(h);
  endtask

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load the first row at reset settings; this covers every store entry
    // that any later frame can reach.
    for (fx = 0; fx < FILL_PIXELS; fx++) begin
      send_request(REQ_LOAD, 9'(fx), 9'd0, 8'($urandom_range(0, 255)));
    end

    // Corners of a one-line frame at the reset mode.
    settle();
    configure(4'd1, 10'd512, 10'd1);
    send_request(REQ_EMIT, 9'd0,   9'd0,   8'h00);
    send_request(REQ_EMIT, 9'd511, 9'd511, 8'hff);
    send_request(REQ_EMIT, 9'd0,   9'd511, 8'h00);
    send_request(REQ_EMIT, 9'd511, 9'd0,   8'h00);
    send_request(REQ_LOAD, 9'd0,   9'd0,   8'hff);
    send_request(REQ_LOAD, 9'd511, 9'd511, 8'h00);
    send_request(REQ_EMIT, 9'd0,   9'd0,   8'h00);
    send_request(REQ_EMIT, 9'd511, 9'd511, 8'h00);

    // Mode past the table, zero width, height past the maximum. A load
    // outside the one-column frame is dropped; an emit outside is served.
    settle();
    configure(4'd15, 10'd0, 10'd1023);
    send_request(REQ_LOAD, 9'd3,   9'd0,   8'h55);
    send_request(REQ_LOAD, 9'd0,   9'd7,   8'haa);
    send_request(REQ_EMIT, 9'd0,   9'd0,   8'h00);
    send_request(REQ_EMIT, 9'd511, 9'd511, 8'h00);

    // Widest shift, width past the maximum, zero height.
    settle();
    configure(4'd0, 10'd1023, 10'd0);
    send_request(REQ_LOAD, 9'd0,   9'd5,   8'h55);
    send_request(REQ_EMIT, 9'd100, 9'd0,   8'h00);
    send_request(REQ_EMIT, 9'd0,   9'd300, 8'h00);

    // Narrowest shift on a two-dimensional frame.
    settle();
    configure(4'd8, 10'd16, 10'd32);
    send_request(REQ_EMIT, 9'd256, 9'd256, 8'h00);
    send_request(REQ_EMIT, 9'd1,   9'd1,   8'h00);

    // Random phases, each with its own settings.
    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      settle();
      wv = pick_dim();
      hv = pick_height(dim_in_use(wv));
      configure(4'($urandom_range(0, 15)), wv, hv);
      idle_on   = ($urandom_range(0, 2) != 0);
      phase_len = $urandom_range(40, 140);
      for (k = 0; k < phase_len && items_done < RANDOM_ITEMS; k++) begin
        if (idle_on && (RANDOM_ITEMS - items_done > CALM_ITEMS) &&
            $urandom_range(0, 5) == 0) begin
          idle_gap($urandom_range(1, 5));
        end
        if ($urandom_range(0, 1) == 1) begin
          // Emit anywhere, or inside the active frame.
          if ($urandom_range(0, 1) == 1) begin
            rx = 9'($urandom_range(0, 511));
            ry = 9'($urandom_range(0, 511));
          end else begin
            rx = 9'($urandom_range(0, act_w - 1));
            ry = 9'($urandom_range(0, act_h - 1));
          end
          send_request(REQ_EMIT, rx, ry, 8'($urandom_range(0, 255)));
          items_done++;
        end else begin
          // Mostly loads that land; some that fall outside the frame.
          if ($urandom_range(0, 7) == 0) begin
            rx = 9'($urandom_range(0, 511));
            ry = 9'($urandom_range(0, 511));
          end else begin
            rx = 9'($urandom_range(0, act_w - 1));
            ry = 9'($urandom_range(0, act_h - 1));
          end
          send_request(REQ_LOAD, rx, ry, 8'($urandom_range(0, 255)));
          if (rx < act_w && ry < act_h) begin
            items_done++;
          end
        end
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- random_pixel_jitter_top.f -----
+incdir+design
design/rpj_pkg.sv
design/rpj_front.sv
design/rpj_fifo.sv
design/rpj_back.sv
design/random_pixel_jitter_top.sv
dv/random_pixel_jitter_checker.sv
dv/testbench.sv
